// ----- rtl/ris_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_pkg
// Shared widths, types and constants of the RGB integral image block.
// ----------------------------------------------------------------------------
package ris_pkg;

   // Frame geometry
   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = 13;
   localparam int EFF_W     = (WID_W > COL_W + 1) ? WID_W : COL_W + 1;

   // Pixel and sum widths
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = 8;
   localparam int PIX_SQ_W   = 2 * PIX_W;
   localparam int ROW_SUM_W  = 20;
   localparam int ROW_SQ_W   = 28;
   localparam int SUM_W      = 32;
   localparam int SQ_W       = 40;

   // Channel order: index 0 red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_type;

   // One stored integral entry; sums sit in the low bits, red lowest
   typedef struct packed {
      logic [NUM_CH-1:0][SQ_W-1:0]  sq;
      logic [NUM_CH-1:0][SUM_W-1:0] sum;
   } line_type;

   // Item leaving the row accumulator toward the merge stage
   typedef struct packed {
      logic [COL_W-1:0]                 col;
      logic                             first_row;
      logic [NUM_CH-1:0][ROW_SQ_W-1:0]  row_sq;
      logic [NUM_CH-1:0][ROW_SUM_W-1:0] row_sum;
   } front_type;

endpackage

// ----- rtl/ris_line_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_line_mem
// One-row store of previous-row integrals, one write and one registered read
// port, read-first on a same-address collision.
// ----------------------------------------------------------------------------
module ris_line_mem (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ris_pkg::COL_W-1:0]  rd_addr,
   output ris_pkg::line_type          rd_data,
   input  logic                       wr_en,
   input  logic [ris_pkg::COL_W-1:0]  wr_addr,
   input  ris_pkg::line_type          wr_data
);
   import ris_pkg::*;

   line_type mem [MAX_WIDTH];
   line_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ris_row_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_row_acc
// Column tracking and per-row running sums of values and squares; gives
// the column, first-row flag and updated row sums of the item being taken.
// ----------------------------------------------------------------------------
module ris_row_acc (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       frame_start,
   input  ris_pkg::pix_type           pix,
   input  logic [ris_pkg::WID_W-1:0]  width,
   output ris_pkg::front_type         front
);
   import ris_pkg::*;

   logic [COL_W-1:0]                 col_ff, col_in;
   logic                             first_ff, first_in;
   logic [NUM_CH-1:0][ROW_SUM_W-1:0] row_sum_ff;
   logic [NUM_CH-1:0][ROW_SQ_W-1:0]  row_sq_ff;

   logic [EFF_W-1:0] eff_width;
   logic [COL_W-1:0] col_pre;
   logic             first_pre;
   logic [COL_W-1:0] col_cur;
   logic             first_cur;
   logic [EFF_W-1:0] col_next;
   logic [NUM_CH-1:0][PIX_SQ_W-1:0]  pix_sq;
   logic [NUM_CH-1:0][ROW_SUM_W-1:0] row_sum_in;
   logic [NUM_CH-1:0][ROW_SQ_W-1:0]  row_sq_in;

   // Effective width: zero counts as one, clamp to the line store
   always_comb begin
      if (width == '0) begin
         eff_width = EFF_W'(1);
      end else if (EFF_W'(width) > EFF_W'(MAX_WIDTH)) begin
         eff_width = EFF_W'(MAX_WIDTH);
      end else begin
         eff_width = EFF_W'(width);
      end
   end

   // Column of this item and column of the next one
   always_comb begin
      col_pre   = frame_start ? '0 : col_ff;
      first_pre = frame_start | first_ff;
      // width lowered mid-row: start a new row here
      if (EFF_W'(col_pre) >= eff_width) begin
         col_cur   = '0;
         first_cur = 1'b0;
      end else begin
         col_cur   = col_pre;
         first_cur = first_pre;
      end
      col_next = EFF_W'(col_cur) + EFF_W'(1);
      if (col_next >= eff_width) begin
         col_in   = '0;
         first_in = 1'b0;
      end else begin
         col_in   = col_next[COL_W-1:0];
         first_in = first_cur;
      end
   end

   // Running row sums, restarted at column zero
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         pix_sq[c] = pix[c] * pix[c];
         if (col_cur == '0) begin
            row_sum_in[c] = ROW_SUM_W'(pix[c]);
            row_sq_in[c]  = ROW_SQ_W'(pix_sq[c]);
         end else begin
            row_sum_in[c] = row_sum_ff[c] + ROW_SUM_W'(pix[c]);
            row_sq_in[c]  = row_sq_ff[c] + ROW_SQ_W'(pix_sq[c]);
         end
      end
   end

   // State update on each taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         first_ff   <= 1'b1;
         row_sum_ff <= '0;
         row_sq_ff  <= '0;
      end else if (accept) begin
         col_ff     <= col_in;
         first_ff   <= first_in;
         row_sum_ff <= row_sum_in;
         row_sq_ff  <= row_sq_in;
      end
   end

   assign front.col       = col_cur;
   assign front.first_row = first_cur;
   assign front.row_sum   = row_sum_in;
   assign front.row_sq    = row_sq_in;

endmodule

// ----- rtl/ris_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ris_merge
// Second stage: adds the row sums to the stored row above, forwards a
// same-column write still in flight, writes the line store back and holds
// the output register.
// ----------------------------------------------------------------------------
module ris_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  ris_pkg::front_type         front,
   input  ris_pkg::line_type          above,
   output logic                       in_ready,
   output logic                       wr_en,
   output logic [ris_pkg::COL_W-1:0]  wr_addr,
   output ris_pkg::line_type          wr_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ris_pkg::line_type          out_data
);
   import ris_pkg::*;

   logic      s1_valid_ff;
   front_type s1_ff;
   logic      hit_ff;
   line_type  fwd_ff;
   logic      out_valid_ff;
   line_type  out_ff;

   logic      s1_adv;
   line_type  above_sel;
   line_type  result;

   // Stage advances when the output register is free or draining
   assign s1_adv   = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || s1_adv;

   // Integral of this pixel; first row sees zero above
   always_comb begin
      above_sel = hit_ff ? fwd_ff : above;
      for (int c = 0; c < NUM_CH; c++) begin
         result.sum[c] = SUM_W'(s1_ff.row_sum[c]);
         result.sq[c]  = SQ_W'(s1_ff.row_sq[c]);
         if (!s1_ff.first_row) begin
            result.sum[c] = SUM_W'(s1_ff.row_sum[c]) + above_sel.sum[c];
            result.sq[c]  = SQ_W'(s1_ff.row_sq[c]) + above_sel.sq[c];
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload; the read of a new item misses the write made on the same edge
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff  <= front;
         hit_ff <= s1_adv && (s1_ff.col == front.col);
         fwd_ff <= result;
      end
      if (s1_adv) begin
         out_ff <= result;
      end
   end

   assign wr_en     = s1_adv;
   assign wr_addr   = s1_ff.col;
   assign wr_data   = result;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ----- rtl/rgb_integral_image_with_squares_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_integral_image_with_squares_top
// Summed-area table of an RGB pixel stream with squared-value integrals.
// ----------------------------------------------------------------------------
// Path: the taken item loads the add stage with the line store read on the
// accept edge; the output register takes its result once free or draining.
// Throughput: one item per cycle while the output register is not stalled;
// registered line store reads feed the add stage, with same-column forwarding.
// Reset: synchronous, active high; clears column, row sums and valid flags,
// sets the first-row flag and image_width to 640. Line store is not cleared.
module rgb_integral_image_with_squares_top (
   input  logic         clock,
   input  logic         reset,
   // configuration write: image_width
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [12:0]  csr_data,
   // pixel stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic [0:0]   req_tuser,   // frame_start[0]
   // integral stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [215:0] rsp_tdata    // sum_red[31:0], sum_green[63:32],
                                     // sum_blue[95:64], square_sum_red[135:96],
                                     // square_sum_green[175:136],
                                     // square_sum_blue[215:176]
);
   import ris_pkg::*;

   logic [WID_W-1:0] width_ff;
   logic             accept;
   pix_type          pix;
   front_type        front;
   line_type         above;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   line_type         wr_data;
   line_type         out_data;

   // Width register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WID_W'(640);
      end else if (csr_valid) begin
         width_ff <= csr_data;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign pix[0] = req_tdata[7:0];
   assign pix[1] = req_tdata[15:8];
   assign pix[2] = req_tdata[23:16];

   ris_row_acc u_row_acc (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_tuser[0]),
      .pix         (pix),
      .width       (width_ff),
      .front       (front)
   );

   ris_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (front.col),
      .rd_data (above),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ris_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .front     (front),
      .above     (above),
      .in_ready  (req_tready),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data;

`ifndef SYNTHESIS
   // a written-back item lands in the output register
   a_wr_to_out: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_tvalid)
      else $error("written item did not reach output");

   // no write-back while the output register is stalled
   a_no_wr_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !wr_en)
      else $error("write-back while output stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule

// ----- tb/sv/rgb_integral_image_with_squares_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_integral_image_with_squares_top_tb
// Self-checking bench for the RGB summed-area table with squared integrals.
// Pixels are streamed in raster order under random flow control. A scoreboard
// keeps its own row store and running sums and predicts every integral.
// Results are compared per channel against the oldest prediction.
// ----------------------------------------------------------------------------
import ris_pkg::*;

// Scoreboard: line store, row sums and the queue of predicted integrals
class integral_scoreboard;
   logic [SUM_W-1:0]     above_sum [NUM_CH][MAX_WIDTH];
   logic [SQ_W-1:0]      above_sq  [NUM_CH][MAX_WIDTH];
   bit                   written   [MAX_WIDTH];
   logic [ROW_SUM_W-1:0] row_sum   [NUM_CH];
   logic [ROW_SQ_W-1:0]  row_sq    [NUM_CH];
   int unsigned          col;
   bit                   first_row;
   logic [WID_W-1:0]     width;
   line_type             integral_q[$];
   int                   errors;
   int                   results_seen;

   function new();
      for (int c = 0; c < NUM_CH; c++) begin
         row_sum[c] = '0;
         row_sq[c]  = '0;
      end
      foreach (written[i]) written[i] = 1'b0;
      col          = 0;
      first_row    = 1'b1;
      width        = 13'd640;
      errors       = 0;
      results_seen = 0;
   endfunction

   function int unsigned eff_width();
      if (width == 0) return 1;
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return width;
   endfunction

   function void set_width(logic [WID_W-1:0] w);
      width = w;
   endfunction

   function int pending();
      return integral_q.size();
   endfunction

   // True when this item would read a line store entry never written
   function bit reads_unwritten(bit fs);
      int unsigned c;
      bit          f;
      c = col;
      f = first_row;
      if (fs) begin
         c = 0;
         f = 1'b1;
      end
      if (c >= eff_width()) begin
         c = 0;
         f = 1'b0;
      end
      return !f && !written[c];
   endfunction

   // Advance the model by one accepted pixel and queue its integrals
   function void note_pixel(bit fs, pix_type pix);
      int unsigned w;
      line_type    e;
      logic [15:0] vsq;
      w = eff_width();
      if (fs) begin
         col       = 0;
         first_row = 1'b1;
      end
      if (col >= w) begin
         col       = 0;
         first_row = 1'b0;
      end
      if (col == 0) begin
         for (int c = 0; c < NUM_CH; c++) begin
            row_sum[c] = '0;
            row_sq[c]  = '0;
         end
      end
      for (int c = 0; c < NUM_CH; c++) begin
         vsq        = pix[c] * pix[c];
         row_sum[c] = row_sum[c] + pix[c];
         row_sq[c]  = row_sq[c] + vsq;
         e.sum[c]   = row_sum[c] + (first_row ? '0 : above_sum[c][col]);
         e.sq[c]    = row_sq[c] + (first_row ? '0 : above_sq[c][col]);
         above_sum[c][col] = e.sum[c];
         above_sq[c][col]  = e.sq[c];
      end
      written[col] = 1'b1;
      integral_q.push_back(e);
      col = col + 1;
      if (col >= w) begin
         col       = 0;
         first_row = 1'b0;
      end
   endfunction

   function string chan_name(int c);
      case (c)
         0:       return "red";
         1:       return "green";
         default: return "blue";
      endcase
   endfunction

   task report(string msg);
      if (errors < 30) $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Compare one accepted result with the oldest prediction
   task check_result(line_type got);
      line_type e;
      results_seen++;
      if (integral_q.size() == 0) begin
         report($sformatf("result %0d arrived with nothing pending: %h", results_seen, got));
         return;
      end
      e = integral_q.pop_front();
      for (int c = 0; c < NUM_CH; c++) begin
         if (got.sum[c] !== e.sum[c])
            report($sformatf("result %0d sum_%s got %0d expected %0d",
                             results_seen, chan_name(c), got.sum[c], e.sum[c]));
         if (got.sq[c] !== e.sq[c])
            report($sformatf("result %0d square_sum_%s got %0d expected %0d",
                             results_seen, chan_name(c), got.sq[c], e.sq[c]));
      end
   endtask
endclass

module rgb_integral_image_with_squares_top_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [12:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;    // red[7:0], green[15:8], blue[23:16]
   logic [0:0]   req_tuser;    // frame_start[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [215:0] rsp_tdata;    // sum_red, sum_green, sum_blue,
                               // square_sum_red, square_sum_green, square_sum_blue

   integral_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int idle_count = 0;

   rgb_integral_image_with_squares_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: random stall, check, and watchdog on stalled traffic
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         idle_count <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready)) begin
            idle_count <= 0;
         end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("rgb_integral_image_with_squares_top verification failed");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   // Send one pixel; frame start is forced if the store would be read unwritten
   task automatic send_pixel(bit fs, pix_type pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (sb.reads_unwritten(fs)) fs = 1'b1;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(fs, pix);
   endtask

   // Stop sending and wait for every pending integral
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_width(logic [WID_W-1:0] w);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_width(w);
   endtask

   function automatic pix_type random_pixel();
      pix_type p;
      for (int c = 0; c < NUM_CH; c++) begin
         case ($urandom_range(7))
            0:       p[c] = 8'd0;
            1:       p[c] = 8'd255;
            default: p[c] = PIX_W'($urandom);
         endcase
      end
      return p;
   endfunction

   // Mostly narrow rows; now and then zero, the reset width or at or beyond the max
   function automatic logic [WID_W-1:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return WID_W'(0);
      if (r < 70) return WID_W'($urandom_range(1, 12));
      if (r < 88) return WID_W'($urandom_range(13, 80));
      if (r < 94) return WID_W'(640);
      return WID_W'($urandom_range(4096, 8191));
   endfunction

   // Whole frames with random content; some cut short, some stray frame starts
   task automatic run_frames(int n);
      int          left;
      int          frame_len;
      int unsigned w;
      bit          fs;
      left = n;
      while (left > 0) begin
         w = sb.eff_width();
         if (w > 100) frame_len = $urandom_range(8, 40);
         else frame_len = $urandom_range(1, 5) * w;
         if ($urandom_range(9) == 0) frame_len = $urandom_range(1, frame_len);
         if (frame_len > left) frame_len = left;
         for (int k = 0; k < frame_len; k++) begin
            if (k == 0) fs = ($urandom_range(15) != 0);
            else fs = ($urandom_range(49) == 0);
            send_pixel(fs, random_pixel());
         end
         left -= frame_len;
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_data      = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      send_idle_pct = 31;
      recv_idle_pct = 45;
      sb            = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset width, pixel extremes, frame start mid-row
      // pixels written as {blue, green, red}
      send_pixel(1'b1, {8'd255, 8'd255, 8'd255});
      send_pixel(1'b0, {8'd0, 8'd0, 8'd0});
      send_pixel(1'b0, {8'h0f, 8'haa, 8'h55});
      send_pixel(1'b1, {8'd3, 8'd2, 8'd1});

      // Narrow rows of full-scale pixels so the stored row gets added
      write_width(13'd3);
      send_pixel(1'b1, {8'd255, 8'd255, 8'd255});
      repeat (5) send_pixel(1'b0, {8'd255, 8'd255, 8'd255});
      send_pixel(1'b0, {8'hf0, 8'h55, 8'haa});

      // Zero width behaves as one pixel per row
      write_width(13'd0);
      send_pixel(1'b1, {8'd255, 8'd0, 8'd255});
      send_pixel(1'b0, {8'd0, 8'd255, 8'd0});
      send_pixel(1'b0, {8'd1, 8'd127, 8'd128});

      // Width beyond the maximum is clamped
      write_width(13'd8191);
      send_pixel(1'b1, {8'd9, 8'd8, 8'd7});
      send_pixel(1'b0, {8'd50, 8'd100, 8'd200});

      // Width lowered mid-row wraps to a new row at column zero
      write_width(13'd5);
      send_pixel(1'b1, {8'd10, 8'd20, 8'd30});
      send_pixel(1'b0, {8'd40, 8'd50, 8'd60});
      send_pixel(1'b0, {8'd70, 8'd80, 8'd90});
      write_width(13'd2);
      send_pixel(1'b0, {8'd255, 8'd1, 8'd0});
      send_pixel(1'b0, {8'd0, 8'd254, 8'd255});
      send_pixel(1'b0, {8'd128, 8'd128, 8'd128});

      // Width raised inside a frame, over columns already in the store
      write_width(13'd4096);
      send_pixel(1'b0, {8'd33, 8'd66, 8'd99});
      send_pixel(1'b0, {8'd200, 8'd150, 8'd100});

      // Random frames under three flow-control profiles
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 45;
            end
            1: begin
               send_idle_pct = 45;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int p = 0; p < 4; p++) begin
            write_width(pick_width());
            run_frames(90);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("rgb_integral_image_with_squares_top verification clean");
      end else begin
         $display("rgb_integral_image_with_squares_top verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ris_pkg.sv
rtl/ris_line_mem.sv
rtl/ris_row_acc.sv
rtl/ris_merge.sv
rtl/rgb_integral_image_with_squares_top.sv
tb/sv/rgb_integral_image_with_squares_top_tb.sv
